// ===== src/chja_pkg.sv =====
// package with shared types and constants of the chained hash join block
`timescale 1ns / 1ps
`default_nettype none
package chja_pkg;

  localparam int unsigned PRIMARY_BUCKETS_DEF = 1024;
  localparam int unsigned ROWS_PER_BUCKET_DEF = 2;
  localparam int unsigned POOL_BUCKETS_DEF    = 1024;

  localparam int unsigned MASK_W   = 10;
  localparam int unsigned HCNT_W   = $clog2(MASK_W);
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned ROW_W    = 62;
  localparam int unsigned PROD_W   = 31;

  localparam logic [MASK_W-1:0] MASK_RESET   = 10'h3ff;
  localparam logic [39:0]       PROMO_PREFIX = 40'h50524F4D4F;
  localparam logic [6:0]        DISC_MAX     = 7'd100;
  localparam logic [31:0]       MAX32        = 32'hffff_ffff;
  localparam logic [47:0]       MAX48        = 48'hffff_ffff_ffff;

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_PROBE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_I_HOME,
    ST_I_NEXT,
    ST_I_LINK,
    ST_P_BKT,
    ST_P_ROW,
    ST_P_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [30:0] join_key;
    logic [23:0] price_cents;
    logic [6:0]  discount_hundredths;
    logic [39:0] type_prefix;
  } item_t;

  typedef struct packed {
    logic [31:0] match_total;
    logic [47:0] promo_sum;
    logic [47:0] all_sum;
    status_e     status;
  } result_t;

endpackage
`default_nettype wire

// ===== src/chja_accum.sv =====
// saturating running aggregates of matched rows
`timescale 1ns / 1ps
`default_nettype none
module chja_accum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        add_i,
  input  wire logic                        promo_i,
  input  wire logic [chja_pkg::PROD_W-1:0] prod_i,
  output logic [31:0]                      match_o,
  output logic [47:0]                      promo_o,
  output logic [47:0]                      all_o
);

  logic [31:0] match_q, match_d;
  logic [47:0] promo_q, promo_d;
  logic [47:0] all_q, all_d;
  logic [48:0] all_sum, promo_sum;

  always_comb begin
    all_sum   = {1'b0, all_q} + 49'(prod_i);
    promo_sum = {1'b0, promo_q} + 49'(prod_i);
    match_d   = match_q;
    promo_d   = promo_q;
    all_d     = all_q;
    if (add_i) begin
      if (match_q != chja_pkg::MAX32) begin
        match_d = match_q + 32'd1;
      end
      all_d = all_sum[48] ? chja_pkg::MAX48 : all_sum[47:0];
      if (promo_i) begin
        promo_d = promo_sum[48] ? chja_pkg::MAX48 : promo_sum[47:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      promo_q <= '0;
      all_q   <= '0;
    end else begin
      match_q <= match_d;
      promo_q <= promo_d;
      all_q   <= all_d;
    end
  end

  assign match_o = match_q;
  assign promo_o = promo_q;
  assign all_o   = all_q;

endmodule
`default_nettype wire

// ===== src/chained_hash_join_aggregate.sv =====
// top level of the chained bucket hash join with running aggregation
// After reset the bucket memory is cleared one bucket per cycle, so busy stays high until
// all PRIMARY_BUCKETS + POOL_BUCKETS buckets are cleared. An item is taken when start is
// high and busy low; exactly one result follows on done_o for one cycle and must be
// taken then, since the receiver cannot stall. The bucket index comes straight from the
// masked key when PRIMARY_BUCKETS is a power of two or at least 1024, else from a
// reciprocal multiply, then a multiply and subtract for the remainder. An insert then
// passes through the home bucket, the overflow bucket and the link update as needed, then
// the result state. A probe reads its chain from the bucket memory a bucket at a time and
// each stored row through the row memory, first comparing the key and then adding the
// product if it matches. The block returns to idle after each result before the next
// item can be taken.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_join_aggregate #(
  parameter int unsigned PRIMARY_BUCKETS = chja_pkg::PRIMARY_BUCKETS_DEF,
  parameter int unsigned ROWS_PER_BUCKET = chja_pkg::ROWS_PER_BUCKET_DEF,
  parameter int unsigned POOL_BUCKETS    = chja_pkg::POOL_BUCKETS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire chja_pkg::item_t             item_i,
  output logic                             done_o,
  output chja_pkg::result_t                result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [chja_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned TOTAL  = PRIMARY_BUCKETS + POOL_BUCKETS;
  localparam int unsigned BW     = $clog2(TOTAL);
  localparam int unsigned FW     = $clog2(ROWS_PER_BUCKET + 1);
  localparam int unsigned BKW    = FW + BW;
  localparam int unsigned ROWS   = TOTAL * ROWS_PER_BUCKET;
  localparam int unsigned AW     = $clog2(ROWS);
  localparam int unsigned HW     = $clog2(TOTAL + 2);
  localparam int unsigned PW     = $clog2(POOL_BUCKETS + 1);
  localparam int unsigned RSH    = 2 * chja_pkg::MASK_W;
  localparam int unsigned QW     = chja_pkg::MASK_W + RSH;
  localparam bit HOME_DIRECT = (PRIMARY_BUCKETS >= (1 << chja_pkg::MASK_W)) ||
                               ((PRIMARY_BUCKETS & (PRIMARY_BUCKETS - 1)) == 0);

  localparam logic [FW-1:0]  FULL     = FW'(ROWS_PER_BUCKET);
  localparam logic [BW:0]    TOTAL_X  = (BW + 1)'(TOTAL);
  localparam logic [HW-1:0]  TOTAL_H  = HW'(TOTAL);
  localparam logic [BW-1:0]  LAST_B   = BW'(TOTAL - 1);
  localparam logic [BW-1:0]  PRIM_B   = BW'(PRIMARY_BUCKETS);
  localparam logic [BW-1:0]  PMASK_B  = BW'(PRIMARY_BUCKETS - 1);
  localparam logic [RSH-1:0] RECIP    = RSH'((1 << RSH) / PRIMARY_BUCKETS + 1);
  localparam logic [chja_pkg::MASK_W-1:0] PRIM_M = chja_pkg::MASK_W'(PRIMARY_BUCKETS);
  localparam logic [PW-1:0]  POOL_P   = PW'(POOL_BUCKETS);
  localparam logic [AW-1:0]  RPB_A    = AW'(ROWS_PER_BUCKET);

  logic [BKW-1:0] bkt_mem [TOTAL];
  logic [chja_pkg::ROW_W-1:0] row_mem [ROWS];

  chja_pkg::state_e  state_q, state_d;
  chja_pkg::item_t   item_q, item_d;
  chja_pkg::status_e status_q, status_d;
  logic [chja_pkg::MASK_W-1:0] mask_q;
  logic [BW-1:0]  b_q, b_d, link_q, link_d, nxt_q, nxt_d, fresh_q, fresh_d, clr_q, clr_d;
  logic [FW-1:0]  hf_q, hf_d, n_q, n_d, j_q, j_d;
  logic [PW-1:0]  pool_q, pool_d;
  logic [HW-1:0]  hops_q, hops_d;
  logic [chja_pkg::HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [chja_pkg::MASK_W-1:0] rem_q, rem_d;
  logic           hit_q, hit_d;
  logic [chja_pkg::PROD_W-1:0] prod_q, prod_d;

  logic [BKW-1:0] bk_rd_q, bk_wdata;
  logic [BW-1:0]  bk_raddr, bk_waddr;
  logic           bk_we;
  logic [chja_pkg::ROW_W-1:0] rw_rd_q, rw_wdata;
  logic [AW-1:0]  rw_raddr, rw_waddr;
  logic           rw_we;

  logic [chja_pkg::MASK_W-1:0] mk;
  logic [QW-1:0]  quo_full;
  logic [chja_pkg::MASK_W-1:0] quo_now, quo_mul;
  logic [BW-1:0]  home_now;
  logic           hash_done;
  logic [FW-1:0]  bk_fill;
  logic [BW-1:0]  bk_link;
  logic [BW-1:0]  fol_b;
  logic           fol_end;
  logic [HW-1:0]  hops_inc;
  logic [BW-1:0]  fresh_now;
  logic [30:0]    r_key;
  logic [23:0]    r_price;
  logic [6:0]     r_disc, r_mul;
  logic           acc_add, promo;
  logic [31:0]    match_total;
  logic [47:0]    promo_sum, all_sum;
  logic           cfg_wr;

  assign bk_fill   = bk_rd_q[BKW-1 -: FW];
  assign bk_link   = bk_rd_q[BW-1:0];
  assign mk        = item_q.join_key[chja_pkg::MASK_W-1:0] & mask_q;
  assign quo_full  = QW'(mk) * QW'(RECIP);
  assign quo_now   = quo_full[QW-1:RSH];
  assign quo_mul   = rem_q * PRIM_M;
  assign hash_done = HOME_DIRECT || (hcnt_q == chja_pkg::HCNT_W'(1));
  assign fresh_now = PRIM_B + BW'(pool_q);
  assign hops_inc  = hops_q + HW'(1);
  assign fol_b     = (state_q == chja_pkg::ST_P_BKT) ? bk_link : link_q;
  assign fol_end   = (fol_b == '0) || ({1'b0, fol_b} >= TOTAL_X) || (hops_inc > TOTAL_H);
  assign r_key     = rw_rd_q[61:31];
  assign r_price   = rw_rd_q[30:7];
  assign r_disc    = (rw_rd_q[6:0] > chja_pkg::DISC_MAX) ? chja_pkg::DISC_MAX : rw_rd_q[6:0];
  assign r_mul     = chja_pkg::DISC_MAX - r_disc;
  assign promo     = item_q.type_prefix == chja_pkg::PROMO_PREFIX;

  always_comb begin
    if (HOME_DIRECT) begin
      if (PRIMARY_BUCKETS >= (1 << chja_pkg::MASK_W)) begin
        home_now = BW'(mk);
      end else begin
        home_now = BW'(mk) & PMASK_B;
      end
    end else begin
      home_now = BW'(mk - quo_mul);
    end
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    status_d = status_q;
    b_d      = b_q;
    link_d   = link_q;
    nxt_d    = nxt_q;
    fresh_d  = fresh_q;
    clr_d    = clr_q;
    hf_d     = hf_q;
    n_d      = n_q;
    j_d      = j_q;
    pool_d   = pool_q;
    hops_d   = hops_q;
    hcnt_d   = hcnt_q;
    rem_d    = rem_q;
    hit_d    = hit_q;
    prod_d   = prod_q;
    bk_raddr = '0;
    bk_we    = 1'b0;
    bk_waddr = '0;
    bk_wdata = '0;
    rw_raddr = '0;
    rw_we    = 1'b0;
    rw_waddr = '0;
    rw_wdata = {item_q.join_key, item_q.price_cents, item_q.discount_hundredths};
    acc_add  = 1'b0;
    unique case (state_q)
      chja_pkg::ST_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_q;
        clr_d    = clr_q + BW'(1);
        if (clr_q == LAST_B) begin
          state_d = chja_pkg::ST_IDLE;
        end
      end
      chja_pkg::ST_IDLE: begin
        if (start) begin
          item_d  = item_i;
          rem_d   = '0;
          hcnt_d  = '0;
          hops_d  = '0;
          state_d = chja_pkg::ST_HASH;
        end
      end
      chja_pkg::ST_HASH: begin
        hcnt_d = hcnt_q + chja_pkg::HCNT_W'(1);
        rem_d  = quo_now;
        if (hash_done) begin
          b_d      = home_now;
          bk_raddr = home_now;
          state_d  = item_q.cmd ? chja_pkg::ST_P_BKT : chja_pkg::ST_I_HOME;
        end
      end
      chja_pkg::ST_I_HOME: begin
        hf_d   = bk_fill;
        link_d = bk_link;
        if (bk_fill < FULL) begin
          rw_we    = 1'b1;
          rw_waddr = AW'(b_q) * RPB_A + AW'(bk_fill);
          bk_we    = 1'b1;
          bk_waddr = b_q;
          bk_wdata = {bk_fill + FW'(1), bk_link};
          status_d = chja_pkg::STATUS_STORED;
          state_d  = chja_pkg::ST_DONE;
        end else if ((bk_link != '0) && ({1'b0, bk_link} < TOTAL_X)) begin
          nxt_d    = bk_link;
          bk_raddr = bk_link;
          state_d  = chja_pkg::ST_I_NEXT;
        end else if (pool_q < POOL_P) begin
          fresh_d  = fresh_now;
          pool_d   = pool_q + PW'(1);
          bk_we    = 1'b1;
          bk_waddr = fresh_now;
          bk_wdata = {FW'(1), bk_link};
          rw_we    = 1'b1;
          rw_waddr = AW'(fresh_now) * RPB_A;
          state_d  = chja_pkg::ST_I_LINK;
        end else begin
          status_d = chja_pkg::STATUS_DROPPED;
          state_d  = chja_pkg::ST_DONE;
        end
      end
      chja_pkg::ST_I_NEXT: begin
        if (bk_fill < FULL) begin
          rw_we    = 1'b1;
          rw_waddr = AW'(nxt_q) * RPB_A + AW'(bk_fill);
          bk_we    = 1'b1;
          bk_waddr = nxt_q;
          bk_wdata = {bk_fill + FW'(1), bk_link};
          status_d = chja_pkg::STATUS_STORED;
          state_d  = chja_pkg::ST_DONE;
        end else if (pool_q < POOL_P) begin
          fresh_d  = fresh_now;
          pool_d   = pool_q + PW'(1);
          bk_we    = 1'b1;
          bk_waddr = fresh_now;
          bk_wdata = {FW'(1), link_q};
          rw_we    = 1'b1;
          rw_waddr = AW'(fresh_now) * RPB_A;
          state_d  = chja_pkg::ST_I_LINK;
        end else begin
          status_d = chja_pkg::STATUS_DROPPED;
          state_d  = chja_pkg::ST_DONE;
        end
      end
      chja_pkg::ST_I_LINK: begin
        bk_we    = 1'b1;
        bk_waddr = b_q;
        bk_wdata = {hf_q, fresh_q};
        status_d = chja_pkg::STATUS_STORED;
        state_d  = chja_pkg::ST_DONE;
      end
      chja_pkg::ST_P_BKT: begin
        n_d    = (bk_fill > FULL) ? FULL : bk_fill;
        link_d = bk_link;
        if (bk_fill == '0) begin
          hops_d = hops_inc;
          if (fol_end) begin
            status_d = chja_pkg::STATUS_PROBE;
            state_d  = chja_pkg::ST_DONE;
          end else begin
            b_d      = fol_b;
            bk_raddr = fol_b;
          end
        end else begin
          j_d      = '0;
          rw_raddr = AW'(b_q) * RPB_A;
          state_d  = chja_pkg::ST_P_ROW;
        end
      end
      chja_pkg::ST_P_ROW: begin
        hit_d   = r_key == item_q.join_key;
        prod_d  = chja_pkg::PROD_W'(r_price * r_mul);
        state_d = chja_pkg::ST_P_ACC;
      end
      chja_pkg::ST_P_ACC: begin
        acc_add = hit_q;
        if ((j_q + FW'(1)) < n_q) begin
          j_d      = j_q + FW'(1);
          rw_raddr = AW'(b_q) * RPB_A + AW'(j_q + FW'(1));
          state_d  = chja_pkg::ST_P_ROW;
        end else begin
          hops_d = hops_inc;
          if (fol_end) begin
            status_d = chja_pkg::STATUS_PROBE;
            state_d  = chja_pkg::ST_DONE;
          end else begin
            b_d      = fol_b;
            bk_raddr = fol_b;
            state_d  = chja_pkg::ST_P_BKT;
          end
        end
      end
      chja_pkg::ST_DONE: begin
        state_d = chja_pkg::ST_IDLE;
      end
      default: begin
        state_d = chja_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) begin
      bkt_mem[bk_waddr] <= bk_wdata;
    end
    bk_rd_q <= bkt_mem[bk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rw_we) begin
      row_mem[rw_waddr] <= rw_wdata;
    end
    rw_rd_q <= row_mem[rw_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chja_pkg::ST_CLEAR;
      clr_q   <= '0;
      pool_q  <= '0;
      mask_q  <= chja_pkg::MASK_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pool_q  <= pool_d;
      if (cfg_wr) begin
        mask_q <= pwdata[chja_pkg::MASK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    b_q      <= b_d;
    link_q   <= link_d;
    nxt_q    <= nxt_d;
    fresh_q  <= fresh_d;
    hf_q     <= hf_d;
    n_q      <= n_d;
    j_q      <= j_d;
    hops_q   <= hops_d;
    hcnt_q   <= hcnt_d;
    rem_q    <= rem_d;
    hit_q    <= hit_d;
    prod_q   <= prod_d;
  end

  chja_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (acc_add),
    .promo_i (promo),
    .prod_i  (prod_q),
    .match_o (match_total),
    .promo_o (promo_sum),
    .all_o   (all_sum)
  );

  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32 - chja_pkg::MASK_W){1'b0}}, mask_q};
  assign pready = 1'b1;

  assign busy   = state_q != chja_pkg::ST_IDLE;
  assign done_o = state_q == chja_pkg::ST_DONE;
  assign result_o.match_total = match_total;
  assign result_o.promo_sum   = promo_sum;
  assign result_o.all_sum     = all_sum;
  assign result_o.status      = status_q;

endmodule
`default_nettype wire

// ===== src/chja_checker.sv =====
// port level checks of the hash join block and their binding
`timescale 1ns / 1ps
`default_nettype none
module chja_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire chja_pkg::result_t result_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("item taken without going busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy ##1 !busy))
    else $error("block not idle after result");

  a_total_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != chja_pkg::STATUS_PROBE)) |->
      (result_o.match_total == $past(result_o.match_total)))
    else $error("insert item changed match total");

endmodule

bind chained_hash_join_aggregate chja_checker u_chja_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
